@@ src/dec_pkg.sv @@
package dec_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_REVERSE    = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

endpackage

@@ src/double_ended_queue.sv @@
// Channel   Valid        Stall         Payload
// --------  -----------  ------------  ----------------------------------------------
// command   i_in_valid   o_in_stall    i_command, i_data_value
// result    o_out_valid  i_out_stall   o_front_value, o_back_value, o_entry_count,
//                                      o_is_empty, o_status
//
// Each command passes through S_IDLE and S_FIN: the accept in S_IDLE updates head,
// count and direction, writes a pushed word and issues a ring read; S_FIN
// takes the registered read data and loads the result register.
// One read port serves the refill after a pop.
// Reset (i_rst_n low, synchronous) empties the deque, natural order; ring
// contents are not cleared and need no clearing pass.
// A stalled result holds in the output register; the block waits in
// S_FIN until that register frees up, then takes the next command.
module double_ended_queue #(
    parameter int CAPACITY   = dec_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = dec_pkg::DEF_DATA_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [dec_pkg::CMD_W-1:0]       i_command,
    input  logic [DATA_WIDTH-1:0]           i_data_value,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [DATA_WIDTH-1:0]           o_front_value,
    output logic [DATA_WIDTH-1:0]           o_back_value,
    output logic [$clog2(CAPACITY+1)-1:0]   o_entry_count,
    output logic                            o_is_empty,
    output logic [dec_pkg::STATUS_W-1:0]    o_status
);

    import dec_pkg::*;

    localparam int AW = $clog2(CAPACITY);       // ring slot index
    localparam int CW = $clog2(CAPACITY + 1);   // count, 0..CAPACITY

    localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);
    localparam logic [AW:0]   CAP_SUM   = (AW+1)'(CAPACITY);
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

    typedef enum logic {
        S_IDLE,
        S_FIN
    } t_state;

    // head + offset, folded back into the ring (sum is below twice the capacity)
    function automatic logic [AW-1:0] f_wrap(input logic [AW:0] sum);
        logic [AW:0] folded;
        folded = (sum >= CAP_SUM) ? (sum - CAP_SUM) : sum;
        return folded[AW-1:0];
    endfunction

    t_state                r_state, n_state;
    logic [AW-1:0]         r_head, n_head;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_rev, n_rev;
    // cached words at the physical start and end of the ring
    logic [DATA_WIDTH-1:0] r_start_word, n_start_word;
    logic [DATA_WIDTH-1:0] r_end_word, n_end_word;
    // pending refill from the ring read issued at accept
    logic                  r_rd_start, n_rd_start;
    logic                  r_rd_end, n_rd_end;
    t_status               r_pend_status, n_pend_status;
    // result register
    logic                  r_out_valid, n_out_valid;
    logic [DATA_WIDTH-1:0] r_front, n_front;
    logic [DATA_WIDTH-1:0] r_back, n_back;
    logic [CW-1:0]         r_out_count, n_out_count;
    logic                  r_out_empty, n_out_empty;
    t_status               r_status, n_status;

    logic                  in_xfer;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;
    logic                  at_start;
    logic [DATA_WIDTH-1:0] fin_start;
    logic [DATA_WIDTH-1:0] fin_end;
    t_cmd                  cmd;

    assign in_xfer = i_in_valid && !o_in_stall;
    assign cmd     = t_cmd'(i_command);

    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_count       = r_count;
        n_rev         = r_rev;
        n_start_word  = r_start_word;
        n_end_word    = r_end_word;
        n_rd_start    = r_rd_start;
        n_rd_end      = r_rd_end;
        n_pend_status = r_pend_status;
        n_out_valid   = r_out_valid && i_out_stall;
        n_front       = r_front;
        n_back        = r_back;
        n_out_count   = r_out_count;
        n_out_empty   = r_out_empty;
        n_status      = r_status;
        wr_en         = 1'b0;
        wr_addr       = r_head;
        rd_en         = 1'b0;
        rd_addr       = r_head;
        at_start      = 1'b0;
        fin_start     = r_rd_start ? rd_data : r_start_word;
        fin_end       = r_rd_end ? rd_data : r_end_word;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state       = S_FIN;
                    n_rd_start    = 1'b0;
                    n_rd_end      = 1'b0;
                    n_pend_status = ST_DONE;
                    case (cmd)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                            if (r_count == CAP_CNT) begin
                                n_pend_status = ST_FULL;
                            end else begin
                                // logical front is the physical start unless reversed
                                at_start = (cmd == CMD_PUSH_FRONT) != r_rev;
                                wr_en    = 1'b1;
                                n_count  = r_count + CW'(1);
                                if (at_start) begin
                                    n_head       = (r_head == '0) ? LAST_SLOT
                                                                  : r_head - AW'(1);
                                    wr_addr      = n_head;
                                    n_start_word = i_data_value;
                                    if (r_count == '0) begin
                                        n_end_word = i_data_value;
                                    end
                                end else begin
                                    wr_addr    = f_wrap({1'b0, r_head} + (AW+1)'(r_count));
                                    n_end_word = i_data_value;
                                    if (r_count == '0) begin
                                        n_start_word = i_data_value;
                                    end
                                end
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK: begin
                            if (r_count == '0) begin
                                n_pend_status = ST_EMPTY;
                            end else begin
                                at_start = (cmd == CMD_POP_FRONT) != r_rev;
                                n_count  = r_count - CW'(1);
                                if (at_start) begin
                                    n_head = (r_head == LAST_SLOT) ? '0 : r_head + AW'(1);
                                    if (r_count == CW'(2)) begin
                                        n_start_word = r_end_word;
                                    end else if (r_count > CW'(2)) begin
                                        rd_en      = 1'b1;
                                        rd_addr    = n_head;
                                        n_rd_start = 1'b1;
                                    end
                                end else begin
                                    if (r_count == CW'(2)) begin
                                        n_end_word = r_start_word;
                                    end else if (r_count > CW'(2)) begin
                                        rd_en    = 1'b1;
                                        rd_addr  = f_wrap({1'b0, r_head}
                                                          + (AW+1)'(r_count - CW'(2)));
                                        n_rd_end = 1'b1;
                                    end
                                end
                            end
                        end
                        CMD_REVERSE: begin
                            n_rev = !r_rev;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FIN: begin
                // load the result once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_state      = S_IDLE;
                    n_start_word = fin_start;
                    n_end_word   = fin_end;
                    n_rd_start   = 1'b0;
                    n_rd_end     = 1'b0;
                    n_out_valid  = 1'b1;
                    n_out_count  = r_count;
                    n_out_empty  = (r_count == '0);
                    n_status     = r_pend_status;
                    if (r_count == '0) begin
                        n_front = '0;
                        n_back  = '0;
                    end else begin
                        n_front = r_rev ? fin_end : fin_start;
                        n_back  = r_rev ? fin_start : fin_end;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_rev       <= 1'b0;
            r_rd_start  <= 1'b0;
            r_rd_end    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_rev       <= n_rev;
            r_rd_start  <= n_rd_start;
            r_rd_end    <= n_rd_end;
            r_out_valid <= n_out_valid;
        end
        r_start_word  <= n_start_word;
        r_end_word    <= n_end_word;
        r_pend_status <= n_pend_status;
        r_front       <= n_front;
        r_back        <= n_back;
        r_out_count   <= n_out_count;
        r_out_empty   <= n_out_empty;
        r_status      <= n_status;
    end

    dec_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_data_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_front_value = r_front;
    assign o_back_value  = r_back;
    assign o_entry_count = r_out_count;
    assign o_is_empty    = r_out_empty;
    assign o_status      = r_status;

    // count never passes the ring size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("entry count beyond capacity");

    // an accepted command always enters S_FIN after its accept
    a_two_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_FIN))
        else $error("accepted command did not enter finish cycle");

    // an empty result carries zero words
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_empty) |-> (o_front_value == '0 && o_back_value == '0))
        else $error("empty result with nonzero words");

    // a refused push only when full
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_status == ST_FULL) |-> (o_entry_count == CAP_CNT))
        else $error("push refused below capacity");

    // a refused pop only when empty
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_status == ST_EMPTY) |-> o_is_empty)
        else $error("pop refused on nonempty deque");

endmodule

@@ src/dec_ram.sv @@
module dec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
